>>> hdl/svm_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and sizes for the stack machine step unit
package svm_pkg;

   localparam int WORD_W      = 32;
   localparam int PROG_DEPTH  = 256;
   localparam int PROG_AW     = $clog2(PROG_DEPTH);
   localparam int LEN_W       = PROG_AW + 1;
   localparam int STACK_DEPTH = 64;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int REG_COUNT   = 16;
   localparam int REG_AW      = $clog2(REG_COUNT);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [REG_AW-1:0] ridx_type;
   typedef logic [1:0]        req_op_type;
   typedef logic [4:0]        ins_type;
   typedef logic [4:0]        step_type;

   // register file slots
   localparam ridx_type R_A   = ridx_type'(0);
   localparam ridx_type R_B   = ridx_type'(1);
   localparam ridx_type R_C   = ridx_type'(2);
   localparam ridx_type R_SP  = ridx_type'(12);
   localparam ridx_type R_IP  = ridx_type'(13);
   localparam ridx_type R_JMP = ridx_type'(14);
   localparam ridx_type R_RUN = ridx_type'(15);

   // request opcodes
   localparam req_op_type REQ_LOAD  = 2'd0;
   localparam req_op_type REQ_CLEAR = 2'd1;
   localparam req_op_type REQ_TICK  = 2'd2;

   // instruction codes
   localparam ins_type OP_HLT  = 5'd0;
   localparam ins_type OP_PSH  = 5'd1;
   localparam ins_type OP_POP  = 5'd2;
   localparam ins_type OP_ADD  = 5'd3;
   localparam ins_type OP_MUL  = 5'd4;
   localparam ins_type OP_DIV  = 5'd5;
   localparam ins_type OP_SUB  = 5'd6;
   localparam ins_type OP_MOD  = 5'd7;
   localparam ins_type OP_SLT  = 5'd8;
   localparam ins_type OP_MOV  = 5'd9;
   localparam ins_type OP_SET  = 5'd10;
   localparam ins_type OP_LOG  = 5'd11;
   localparam ins_type OP_LOGR = 5'd12;
   localparam ins_type OP_LOGS = 5'd13;
   localparam ins_type OP_IF   = 5'd14;
   localparam ins_type OP_IFN  = 5'd15;
   localparam ins_type OP_GLD  = 5'd16;
   localparam ins_type OP_GPT  = 5'd17;
   localparam ins_type OP_NOP  = 5'd18;
   localparam ins_type OP_UNK  = 5'd31;

   // sequencer steps, also the controller state codes
   localparam step_type ST_IDLE  = 5'd0;
   localparam step_type ST_TICK0 = 5'd1;
   localparam step_type ST_F1    = 5'd2;
   localparam step_type ST_F2    = 5'd3;
   localparam step_type ST_F3    = 5'd4;
   localparam step_type ST_F4    = 5'd5;
   localparam step_type ST_R1    = 5'd6;
   localparam step_type ST_R2    = 5'd7;
   localparam step_type ST_EX    = 5'd8;
   localparam step_type ST_BA    = 5'd9;
   localparam step_type ST_BB    = 5'd10;
   localparam step_type ST_BC    = 5'd11;
   localparam step_type ST_BE    = 5'd12;
   localparam step_type ST_BD    = 5'd13;
   localparam step_type ST_LS    = 5'd14;
   localparam step_type ST_LS2   = 5'd15;
   localparam step_type ST_GP    = 5'd16;
   localparam step_type ST_GP2   = 5'd17;
   localparam step_type ST_ADV   = 5'd18;
   localparam step_type ST_FIN   = 5'd19;

   typedef struct packed {
      step_type step;
      logic     accept;
      logic     rsp_load;
   } svm_cmd_type;

   typedef struct packed {
      ins_type op;
      logic    tick_ok;
      logic    div_zero;
      logic    div_done;
   } svm_sts_type;

endpackage

>>> hdl/svm_if.sv
`timescale 1ns / 1ps
// request and response channel interfaces
interface svm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [31:0] word;

   modport source (output valid, output opcode, output word, input ready);
   modport sink (input valid, input opcode, input word, output ready);
endinterface

interface svm_rsp_if;
   logic               valid;
   logic               ready;
   logic               log_valid;
   logic signed [31:0] log_value;
   logic               running;
   logic               finished;
   logic               unknown_op;
   logic               divide_fault;
   logic               program_full;

   modport source (output valid, output log_valid, output log_value, output running,
                   output finished, output unknown_op, output divide_fault,
                   output program_full, input ready);
   modport sink (input valid, input log_valid, input log_value, input running,
                 input finished, input unknown_op, input divide_fault,
                 input program_full, output ready);
endinterface

>>> hdl/stack_vm_step_unit_top.sv
`timescale 1ns / 1ps
// stack machine step unit: one request in, one result out
//
// req_if carries an opcode (load word, clear, tick) and a program word; a
// transfer happens when valid and ready are both high. rsp_if returns one
// result per request: log flag and value, running, finished and the fault
// flags. A new request is taken only when the sequencer is idle, but the
// result register lets the next request in while a result still waits.
// Load, clear and a tick that runs nothing go straight to the final step.
// A tick that runs an instruction takes four program memory reads
// through the single read port, two register reads, execute and ip
// update; stack arithmetic adds its own steps, and DIV or MOD also waits
// for the bit-serial divider. Synchronous reset empties the program,
// zeroes the registers except SP (all ones) and marks the whole stack as
// zero. While rsp_if.ready is low a waiting result holds, and a sequencer
// that reaches its final step waits there.
module stack_vm_step_unit_top import svm_pkg::*; (
   input logic          clock,
   input logic          reset,
   svm_req_if.sink      req_if,
   svm_rsp_if.source    rsp_if
);

   svm_cmd_type cmd;
   svm_sts_type sts;

   svm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_opcode (req_if.opcode),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   svm_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_opcode   (req_if.opcode),
      .req_word     (req_if.word),
      .log_valid    (rsp_if.log_valid),
      .log_value    (rsp_if.log_value),
      .running      (rsp_if.running),
      .finished     (rsp_if.finished),
      .unknown_op   (rsp_if.unknown_op),
      .divide_fault (rsp_if.divide_fault),
      .program_full (rsp_if.program_full)
   );

endmodule

>>> hdl/svm_div.sv
`timescale 1ns / 1ps
// unsigned restoring divider, one quotient bit per cycle
module svm_div import svm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type dividend,
   input  word_type divisor,
   output logic     done,
   output word_type quotient,
   output word_type remainder
);

   localparam int CNT_W = $clog2(WORD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   word_type         quo_ff, quo_in;
   word_type         rem_ff, rem_in;
   word_type         dvs_ff, dvs_in;
   logic [WORD_W:0]  shifted;
   logic [WORD_W:0]  diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[WORD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WORD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // top bit of diff is the borrow
         if (!diff[WORD_W]) begin
            rem_in = diff[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_last_bit_done: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && cnt_ff == CNT_W'(1) |=> done_ff && !busy_ff)
      else $error("divider missed its done pulse");

endmodule

>>> hdl/svm_dpath.sv
`timescale 1ns / 1ps
// datapath: program memory, register file, operand stack, alu and result register
module svm_dpath import svm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  svm_cmd_type        cmd,
   output svm_sts_type        sts,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_word,
   output logic               log_valid,
   output logic signed [31:0] log_value,
   output logic               running,
   output logic               finished,
   output logic               unknown_op,
   output logic               divide_fault,
   output logic               program_full
);

   function automatic word_type mag(input word_type x);
      return x[WORD_W-1] ? word_type'(-x) : x;
   endfunction

   word_type             rf_ff [REG_COUNT];
   logic [LEN_W-1:0]     len_ff, len_in;
   word_type             prog_mem [PROG_DEPTH];
   word_type             stack_mem [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] vld_ff;

   word_type pm_q_ff, sq_ff;
   logic     pm_ok_ff, sqv_ff;
   ins_type  ins_ff;
   word_type op1_ff, op2_ff, op3_ff, rv1_ff, rv2_ff;
   logic     taken_ff, neg_ff, mod_ff;
   logic     lv_ff, unk_ff, dflt_ff, full_ff;
   word_type logv_ff;

   logic     out_lv_ff, out_run_ff, out_fin_ff, out_unk_ff, out_dflt_ff, out_full_ff;
   word_type out_logv_ff;

   word_type ip, sp, jmp, a, b, len_ext, fv, sq;
   word_type sp_inc, sp_dec, pm_addr, gld_val, alu_c, div_c, ip_next, ls_ofs;
   logic [1:0] pm_ofs, adv_k;
   ins_type  dec;
   ridx_type idx1, rd_idx;
   logic     load_now, clear_now, prog_full, is_if, taken, div_zero, is_div;
   logic [STACK_AW-1:0] stk_raddr;

   logic     rf_we, sp_we, ip_we, stk_we, div_start, div_done;
   ridx_type rf_widx;
   word_type rf_wdata, sp_wdata, stk_wdata, dvd, dvs, quo, rem, div_r;
   logic [STACK_AW-1:0] stk_waddr;

   assign ip      = rf_ff[R_IP];
   assign sp      = rf_ff[R_SP];
   assign jmp     = rf_ff[R_JMP];
   assign a       = rf_ff[R_A];
   assign b       = rf_ff[R_B];
   assign len_ext = {{(WORD_W-LEN_W){1'b0}}, len_ff};
   assign fv      = pm_ok_ff ? pm_q_ff : '0;
   assign sq      = sqv_ff ? sq_ff : '0;
   assign sp_inc  = sp + 1'b1;
   assign sp_dec  = sp - 1'b1;
   assign ls_ofs  = sp - rv1_ff;
   assign idx1    = op1_ff[REG_AW-1:0];

   assign load_now  = cmd.accept && req_opcode == REQ_LOAD;
   assign clear_now = cmd.accept && req_opcode == REQ_CLEAR;
   assign prog_full = len_ff >= LEN_W'(PROG_DEPTH);

   assign dec = (fv <= {{(WORD_W-5){1'b0}}, OP_NOP}) ? fv[4:0] : OP_UNK;

   always_comb begin
      unique case (cmd.step)
         ST_F1:   pm_ofs = 2'd1;
         ST_F2:   pm_ofs = 2'd2;
         ST_F3:   pm_ofs = 2'd3;
         default: pm_ofs = 2'd0;
      endcase
   end
   assign pm_addr = ip + {{(WORD_W-2){1'b0}}, pm_ofs};

   assign rd_idx = (cmd.step == ST_R2) ? op2_ff[REG_AW-1:0] : idx1;

   always_comb begin
      unique case (cmd.step)
         ST_BB:   stk_raddr = sp_dec[STACK_AW-1:0];
         ST_LS:   stk_raddr = ls_ofs[STACK_AW-1:0];
         default: stk_raddr = sp[STACK_AW-1:0];
      endcase
   end

   // gld reads sp as it stands after the push, and ip plus one
   always_comb begin
      if (idx1 == R_SP)
         gld_val = sp_inc;
      else if (idx1 == R_IP)
         gld_val = ip + 1'b1;
      else
         gld_val = rv1_ff;
   end

   assign is_if    = ins_ff == OP_IF || ins_ff == OP_IFN;
   assign taken    = (rv1_ff == op2_ff) == (ins_ff == OP_IF);
   assign is_div   = ins_ff == OP_DIV || ins_ff == OP_MOD;
   assign div_zero = (ins_ff == OP_DIV) ? (a == '0) : (b == '0);
   assign dvd      = (ins_ff == OP_DIV) ? mag(b) : mag(a);
   assign dvs      = (ins_ff == OP_DIV) ? mag(a) : mag(b);
   assign div_r    = mod_ff ? rem : quo;
   assign div_c    = neg_ff ? word_type'(-div_r) : div_r;

   always_comb begin
      unique case (ins_ff)
         OP_ADD:  alu_c = b + a;
         OP_SUB:  alu_c = b - a;
         OP_MUL:  alu_c = word_type'(b * a);
         default: alu_c = '0;
      endcase
   end

   always_comb begin
      unique case (ins_ff)
         OP_PSH, OP_LOG, OP_LOGR, OP_LOGS, OP_GLD, OP_GPT: adv_k = 2'd1;
         OP_SLT, OP_MOV, OP_SET:                           adv_k = 2'd2;
         OP_IF, OP_IFN:                                    adv_k = 2'd3;
         default:                                          adv_k = 2'd0;
      endcase
   end
   assign ip_next = (is_if && taken_ff) ? op3_ff :
                    ip + {{(WORD_W-2){1'b0}}, adv_k} + {{(WORD_W-1){1'b0}}, jmp == '0};

   svm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dvd),
      .divisor   (dvs),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   // write port selection per step
   always_comb begin
      rf_we     = 1'b0;
      rf_widx   = R_A;
      rf_wdata  = '0;
      sp_we     = 1'b0;
      sp_wdata  = sp_dec;
      ip_we     = 1'b0;
      stk_we    = 1'b0;
      stk_waddr = sp[STACK_AW-1:0];
      stk_wdata = '0;
      div_start = 1'b0;
      unique case (cmd.step)
         ST_TICK0: begin
            rf_we   = 1'b1;
            rf_widx = R_JMP;
         end
         ST_EX: begin
            unique case (ins_ff)
               OP_HLT: begin
                  rf_we   = 1'b1;
                  rf_widx = R_RUN;
               end
               OP_PSH: begin
                  sp_we     = 1'b1;
                  sp_wdata  = sp_inc;
                  stk_we    = 1'b1;
                  stk_waddr = sp_inc[STACK_AW-1:0];
                  stk_wdata = op1_ff;
               end
               OP_POP: begin
                  sp_we = 1'b1;
               end
               OP_SLT: begin
                  sp_we     = 1'b1;
                  stk_we    = 1'b1;
                  stk_waddr = sp_dec[STACK_AW-1:0];
                  stk_wdata = {{(WORD_W-1){1'b0}}, $signed(rv1_ff) < $signed(rv2_ff)};
               end
               OP_MOV: begin
                  rf_we    = 1'b1;
                  rf_widx  = op2_ff[REG_AW-1:0];
                  rf_wdata = rv1_ff;
               end
               OP_SET: begin
                  rf_we    = 1'b1;
                  rf_widx  = idx1;
                  rf_wdata = op2_ff;
               end
               OP_IF, OP_IFN: begin
                  rf_we    = taken;
                  rf_widx  = R_JMP;
                  rf_wdata = {{(WORD_W-1){1'b0}}, 1'b1};
               end
               OP_GLD: begin
                  sp_we     = 1'b1;
                  sp_wdata  = sp_inc;
                  stk_we    = 1'b1;
                  stk_waddr = sp_inc[STACK_AW-1:0];
                  stk_wdata = gld_val;
               end
               default: begin
               end
            endcase
         end
         ST_BB: begin
            rf_we    = 1'b1;
            rf_widx  = R_A;
            rf_wdata = sq;
            sp_we    = 1'b1;
         end
         ST_BC: begin
            rf_we    = 1'b1;
            rf_widx  = R_B;
            rf_wdata = sq;
         end
         ST_BE: begin
            if (is_div && !div_zero) begin
               div_start = 1'b1;
            end else begin
               // divide by zero leaves alu_c at zero
               rf_we     = 1'b1;
               rf_widx   = R_C;
               rf_wdata  = alu_c;
               stk_we    = 1'b1;
               stk_wdata = alu_c;
            end
         end
         ST_BD: begin
            rf_we     = div_done;
            rf_widx   = R_C;
            rf_wdata  = div_c;
            stk_we    = div_done;
            stk_wdata = div_c;
         end
         ST_GP2: begin
            rf_we    = 1'b1;
            rf_widx  = idx1;
            rf_wdata = sq;
         end
         ST_ADV: begin
            ip_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || clear_now) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            rf_ff[i] <= (ridx_type'(i) == R_SP) ? '1 : '0;
         end
      end else begin
         if (rf_we) begin
            rf_ff[rf_widx] <= rf_wdata;
         end
         if (sp_we) begin
            rf_ff[R_SP] <= sp_wdata;
         end
         if (ip_we) begin
            rf_ff[R_IP] <= ip_next;
         end
      end
   end

   always_comb begin
      len_in = len_ff;
      if (clear_now) begin
         len_in = '0;
      end else if (load_now && !prog_full) begin
         len_in = len_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_now && !prog_full) begin
         prog_mem[len_ff[PROG_AW-1:0]] <= word_type'(req_word);
      end
      pm_q_ff  <= prog_mem[pm_addr[PROG_AW-1:0]];
      pm_ok_ff <= pm_addr < len_ext;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      sq_ff <= stack_mem[stk_raddr];
   end

   // entries never written since reset or clear read as zero
   always_ff @(posedge clock) begin
      if (reset || clear_now) begin
         vld_ff <= '0;
      end else if (stk_we) begin
         vld_ff[stk_waddr] <= 1'b1;
      end
      sqv_ff <= vld_ff[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.step == ST_F1) begin
         ins_ff <= dec;
      end
      if (cmd.step == ST_F2) begin
         op1_ff <= fv;
      end
      if (cmd.step == ST_F3) begin
         op2_ff <= fv;
      end
      if (cmd.step == ST_F4) begin
         op3_ff <= fv;
      end
      if (cmd.step == ST_R1) begin
         rv1_ff <= rf_ff[rd_idx];
      end
      if (cmd.step == ST_R2) begin
         rv2_ff <= rf_ff[rd_idx];
      end
      if (cmd.step == ST_EX) begin
         taken_ff <= taken;
      end
      if (cmd.step == ST_BE) begin
         neg_ff <= (ins_ff == OP_DIV) ? (a[WORD_W-1] ^ b[WORD_W-1]) : a[WORD_W-1];
         mod_ff <= ins_ff == OP_MOD;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         lv_ff   <= 1'b0;
         logv_ff <= '0;
         unk_ff  <= 1'b0;
         dflt_ff <= 1'b0;
         full_ff <= load_now && prog_full;
      end else if (cmd.step == ST_EX) begin
         if (ins_ff == OP_LOG) begin
            lv_ff   <= 1'b1;
            logv_ff <= op1_ff;
         end
         if (ins_ff == OP_LOGR) begin
            lv_ff   <= 1'b1;
            logv_ff <= rv1_ff;
         end
         unk_ff <= ins_ff == OP_UNK;
      end else if (cmd.step == ST_LS2) begin
         lv_ff   <= 1'b1;
         logv_ff <= sq;
      end else if (cmd.step == ST_BE) begin
         dflt_ff <= is_div && div_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         out_lv_ff   <= lv_ff;
         out_logv_ff <= logv_ff;
         out_run_ff  <= rf_ff[R_RUN] != '0;
         out_fin_ff  <= ip >= len_ext;
         out_unk_ff  <= unk_ff;
         out_dflt_ff <= dflt_ff;
         out_full_ff <= full_ff;
      end
   end

   assign sts.op       = ins_ff;
   assign sts.tick_ok  = ip < len_ext;
   assign sts.div_zero = div_zero;
   assign sts.div_done = div_done;

   assign log_valid    = out_lv_ff;
   assign log_value    = out_logv_ff[31:0];
   assign running      = out_run_ff;
   assign finished     = out_fin_ff;
   assign unknown_op   = out_unk_ff;
   assign divide_fault = out_dflt_ff;
   assign program_full = out_full_ff;

endmodule

>>> hdl/svm_ctrl.sv
`timescale 1ns / 1ps
// controller: instruction sequencer and channel handshakes
module svm_ctrl import svm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  svm_sts_type sts,
   output svm_cmd_type cmd
);

   step_type state_ff, state_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     accept, load_ok;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   // result register is free or being emptied this cycle
   assign load_ok   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_opcode == REQ_TICK && sts.tick_ok) ? ST_TICK0 : ST_FIN;
            end
         end
         ST_TICK0: state_in = ST_F1;
         ST_F1:    state_in = ST_F2;
         ST_F2:    state_in = ST_F3;
         ST_F3:    state_in = ST_F4;
         ST_F4:    state_in = ST_R1;
         ST_R1:    state_in = ST_R2;
         ST_R2:    state_in = ST_EX;
         ST_EX: begin
            priority if (sts.op == OP_ADD || sts.op == OP_MUL || sts.op == OP_DIV ||
                         sts.op == OP_SUB || sts.op == OP_MOD) begin
               state_in = ST_BA;
            end else if (sts.op == OP_LOGS) begin
               state_in = ST_LS;
            end else if (sts.op == OP_GPT) begin
               state_in = ST_GP;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_BA:    state_in = ST_BB;
         ST_BB:    state_in = ST_BC;
         ST_BC:    state_in = ST_BE;
         ST_BE: begin
            if ((sts.op == OP_DIV || sts.op == OP_MOD) && !sts.div_zero) begin
               state_in = ST_BD;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_BD: begin
            if (sts.div_done) begin
               state_in = ST_ADV;
            end
         end
         ST_LS:    state_in = ST_LS2;
         ST_LS2:   state_in = ST_ADV;
         ST_GP:    state_in = ST_GP2;
         ST_GP2:   state_in = ST_ADV;
         ST_ADV:   state_in = ST_FIN;
         ST_FIN: begin
            if (load_ok) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_FIN && load_ok) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign cmd.step     = state_ff;
   assign cmd.accept   = accept;
   assign cmd.rsp_load = state_ff == ST_FIN && load_ok;

   a_no_tick_direct: assert property (@(posedge clock) disable iff (reset)
      accept && req_opcode != REQ_TICK |=> state_ff == ST_FIN)
      else $error("load or clear did not go straight to finish");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BD && !sts.div_done |=> state_ff == ST_BD)
      else $error("left divide wait before done");

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && rsp_valid_ff && !rsp_ready |=> state_ff == ST_FIN && rsp_valid)
      else $error("result overwritten while stalled");

endmodule
